// File: rtl/core/base64url_stream_encoder_defines.svh
// Assertion macros shared by the encoder modules
`ifndef BASE64URL_STREAM_ENCODER_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

`define B64U_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define B64U_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define B64U_ASSERT(lbl, clk, rst, prop, msg)
`define B64U_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: rtl/core/b64u_pkg.sv
// Types, constants and the character mapping for the base64url encoder
`timescale 1ns / 1ps

package b64u_pkg;

  localparam int GQ_DEPTH = 2;
  localparam int GQ_PTR_W = 1;
  localparam int GQ_CNT_W = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       final_char;
  } out_item_t;

  // One group ready for output: three bytes, index of the last character, end flag
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] last_idx;
    logic       last;
  } group_t;

  localparam logic [1:0] POS_EMPTY = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;

  localparam logic [1:0] IDX_PARTIAL_ONE = 2'd1;
  localparam logic [1:0] IDX_PARTIAL_TWO = 2'd2;
  localparam logic [1:0] IDX_FULL        = 2'd3;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] w;
    logic [7:0] c;
    begin
      w = {2'b00, s};
      if (w < 8'd26) begin
        c = 8'h41 + w;
      end else if (w < 8'd52) begin
        c = 8'h61 + (w - 8'd26);
      end else if (w < 8'd62) begin
        c = 8'h30 + (w - 8'd52);
      end else if (w == 8'd62) begin
        c = 8'h2d;
      end else begin
        c = 8'h5f;
      end
      return c;
    end
  endfunction

  function automatic logic [5:0] group_sextet(input group_t g, input logic [1:0] k);
    logic [5:0] s;
    begin
      case (k)
        2'd0:    s = g.b0[7:2];
        2'd1:    s = {g.b0[1:0], g.b1[7:4]};
        2'd2:    s = {g.b1[3:0], g.b2[7:6]};
        default: s = g.b2[5:0];
      endcase
      return s;
    end
  endfunction

endpackage

// File: rtl/core/b64u_front.sv
// Intake: collects bytes into groups and hands finished groups to the queue
`timescale 1ns / 1ps
`include "base64url_stream_encoder_defines.svh"

module b64u_front import b64u_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     grp_valid,
  output group_t   grp,
  input  logic     grp_full
);

  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [1:0] pos_eff;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic       accept;
  logic       store;

  assign full    = grp_full;
  assign accept  = push && !grp_full;
  assign pos_eff = (pos == POS_EMPTY || pos == POS_ONE) ? pos : POS_TWO;
  assign store   = (pos_eff != POS_TWO) && !in_item.end_of_message;

  assign grp_valid = accept && !store;

  always_comb begin
    grp      = '0;
    grp.last = in_item.end_of_message;
    unique case (pos_eff)
      POS_EMPTY: begin
        grp.b0       = in_item.data_byte;
        grp.last_idx = IDX_PARTIAL_ONE;
      end
      POS_ONE: begin
        grp.b0       = pend0;
        grp.b1       = in_item.data_byte;
        grp.last_idx = IDX_PARTIAL_TWO;
      end
      default: begin
        grp.b0       = pend0;
        grp.b1       = pend1;
        grp.b2       = in_item.data_byte;
        grp.last_idx = IDX_FULL;
      end
    endcase
  end

  always_comb begin
    pos_next = pos;
    if (accept) begin
      pos_next = store ? pos_eff + 2'd1 : POS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_EMPTY;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      if (pos_eff == POS_EMPTY) begin
        pend0 <= in_item.data_byte;
      end else begin
        pend1 <= in_item.data_byte;
      end
    end
  end

  `B64U_NEVER(a_pos_range, clk, rst, pos == 2'd3, "group position reached three")
  `B64U_ASSERT(a_full_group_resets, clk, rst, (grp_valid |=> pos == POS_EMPTY), "position not cleared after group")

endmodule

// File: rtl/core/b64u_grp_fifo.sv
// Short queue of finished groups between intake and output
`timescale 1ns / 1ps
`include "base64url_stream_encoder_defines.svh"

module b64u_grp_fifo import b64u_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  group_t wr_data,
  output logic   full,
  output logic   rd_valid,
  output group_t rd_data,
  input  logic   rd
);

  group_t                mem [GQ_DEPTH];
  logic [GQ_PTR_W-1:0]   wptr;
  logic [GQ_PTR_W-1:0]   rptr;
  logic [GQ_CNT_W-1:0]   cnt;
  logic                  do_wr;
  logic                  do_rd;

  assign full     = (cnt == GQ_CNT_W'(GQ_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + GQ_CNT_W'(do_wr) - GQ_CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  `B64U_NEVER(a_no_overflow, clk, rst, wr && full, "group written into full queue")

endmodule

// File: rtl/core/b64u_back.sv
// Output: walks each group one character a cycle into the result register while it is free or being popped
`timescale 1ns / 1ps
`include "base64url_stream_encoder_defines.svh"

module b64u_back import b64u_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      grp_valid,
  input  group_t    grp,
  output logic      grp_rd,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic       out_valid;
  out_item_t  out_reg;
  logic [1:0] k;
  logic       load;
  logic       at_end;

  assign load   = grp_valid && (!out_valid || pop);
  assign at_end = (k == grp.last_idx);
  assign grp_rd = load && at_end;

  assign empty    = !out_valid;
  assign out_item = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        k         <= at_end ? 2'd0 : k + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg.out_char   <= sextet_char(group_sextet(grp, k));
      out_reg.final_char <= grp.last && at_end;
    end
  end

  `B64U_ASSERT(a_idx_bound, clk, rst, (grp_valid |-> k <= grp.last_idx), "character index past group end")
  `B64U_ASSERT(a_idx_idle, clk, rst, (!grp_valid |-> k == 2'd0), "index left mid-group with queue empty")

endmodule

// File: rtl/core/base64url_stream_encoder.sv
// Top level of the base64url (no padding) stream encoder
`timescale 1ns / 1ps
//
// Channel   Handshake            Payload
// input     push / full          in_item  (data_byte, end_of_message)
// result    empty / pop          out_item (out_char, final_char)
//
// One character leaves per cycle while pop is held high and a group is queued; a full group
// of three bytes yields four characters, so sustained intake is held back by the output side.
// The byte closing a group is written into the group queue, and the first character of
// that group then goes into the result register; a mid-group byte yields none.
// The group queue is two deep; full rises only when it holds two groups.
// Synchronous reset clears the group position, the queue and the result valid flag.

module base64url_stream_encoder import b64u_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic   wr_valid;
  group_t wr_grp;
  logic   q_full;
  logic   rd_valid;
  group_t rd_grp;
  logic   rd;

  b64u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .grp_valid (wr_valid),
    .grp       (wr_grp),
    .grp_full  (q_full)
  );

  b64u_grp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr_valid),
    .wr_data  (wr_grp),
    .full     (q_full),
    .rd_valid (rd_valid),
    .rd_data  (rd_grp),
    .rd       (rd)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (rd_valid),
    .grp       (rd_grp),
    .grp_rd    (rd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// File: verif/base64url_stream_encoder_tb.sv
// Self-checking testbench for the base64url stream encoder
`timescale 1ns / 1ps

module base64url_stream_encoder_tb;
  import b64u_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 200;
  localparam int QUIET_ITEMS = 30;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  // encoder state as predicted
  logic [1:0] grp_pos;
  logic [7:0] held_bytes [2];
  out_item_t  chars_due [$];

  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int stall_left = 0;

  base64url_stream_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64url_stream_encoder_tb: errors");
      $finish;
    end
  end

  function automatic logic [7:0] url_symbol(input logic [5:0] sx);
    return URL_ALPHABET[8*(63 - int'(sx)) +: 8];
  endfunction

  // Advance the predicted encoder by one byte and queue the characters it yields.
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [5:0] sx [4];
    out_item_t  c;
    int         n;
    if (grp_pos != POS_TWO && !eom) begin
      held_bytes[grp_pos[0]] = b;
      grp_pos = grp_pos + 2'd1;
      return;
    end
    case (grp_pos)
      POS_EMPTY: begin
        b0 = b; b1 = 8'h00; b2 = 8'h00; n = 2;
      end
      POS_ONE: begin
        b0 = held_bytes[0]; b1 = b; b2 = 8'h00; n = 3;
      end
      default: begin
        b0 = held_bytes[0]; b1 = held_bytes[1]; b2 = b; n = 4;
      end
    endcase
    sx[0] = b0[7:2];
    sx[1] = {b0[1:0], b1[7:4]};
    sx[2] = {b1[3:0], b2[7:6]};
    sx[3] = b2[5:0];
    for (int k = 0; k < n; k++) begin
      c.out_char = url_symbol(sx[k]);
      c.final_char = eom && (k == n - 1);
      chars_due = {chars_due, c};
    end
    grp_pos = POS_EMPTY;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // Send one request; push stays high on return so the next one can follow at once.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      gap = $urandom_range(15, 1);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item.data_byte <= b;
    in_item.end_of_message <= eom;
    do @(posedge clk); while (full);
    encode_byte(b, eom);
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9, 0))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(255, 0));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (chars_due.size() > 0) @(posedge clk);
  endtask

  // Result side: hold pop low in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pop_stall_pct > 0 && $urandom_range(99, 0) < pop_stall_pct) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(14, 0);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (chars_due.size() == 0) begin
        report_mismatch("unexpected character", out_item.out_char, 8'h00);
      end else begin
        want = chars_due.pop_front();
        if (out_item.out_char !== want.out_char)
          report_mismatch("out_char", out_item.out_char, want.out_char);
        if (out_item.final_char !== want.final_char)
          report_mismatch("final_char", 8'(out_item.final_char), 8'(want.final_char));
      end
    end
  end

  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Final flag lands on the fourth character; the group maps to '-', '_', '-', '_'.
  task automatic test_full_group_end();
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hbf, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_group_then_tail();
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_random_messages(input int item_budget);
    int target;
    int len;
    target = bytes_sent + item_budget;
    while (bytes_sent < target) begin
      send_idle_pct = ($urandom_range(2, 0) == 0) ? 0 : 25;
      pop_stall_pct = ($urandom_range(2, 0) == 0) ? 0 : 20;
      len = ($urandom_range(7, 0) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
      send_message(len);
    end
  endtask

  task automatic test_drain_pause();
    send_message($urandom_range(8, 4));
    wait_drained();
    send_message($urandom_range(8, 4));
  endtask

  task automatic test_quiet_tail();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (bytes_sent < RANDOM_ITEMS + QUIET_ITEMS)
      send_message($urandom_range(7, 1));
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    grp_pos = POS_EMPTY;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_messages();
    send_idle_pct = 30;
    pop_stall_pct = 25;
    test_full_group_end();
    test_group_then_tail();
    test_random_messages(RANDOM_ITEMS / 2);
    test_drain_pause();
    test_random_messages(RANDOM_ITEMS / 2);
    test_quiet_tail();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("base64url_stream_encoder_tb: clean");
    end else begin
      $display("base64url_stream_encoder_tb: errors");
    end
    $finish;
  end

endmodule
